// ===== design/rrbc_pkg.sv =====
// Shared types and constants for the random-replacement byte cache.
// The controller, the datapath and the top level all import this package.
package rrbc_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 40;
  localparam int CAP_W       = 40;
  localparam int USED_W      = 41;
  localparam int SIZE_W      = 32;
  localparam int IN_KEY_W    = 32;
  localparam int CNT_OUT_W   = 48;
  localparam int EVICT_OUT_W = 7;
  localparam int LFSR_W      = 16;
  localparam int DIV_STEP_W  = 4;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 104;
  localparam int OUT_USER_W  = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_CAPACITY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANDOM_SEED   = 2'd1;

  localparam logic [LFSR_W-1:0]    LFSR_TAPS = 16'hB400;
  localparam logic [CNT_OUT_W-1:0] CNT_MAX   = {CNT_OUT_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic srch_rd;
    logic srch_cmp;
    logic do_hit;
    logic do_reject;
    logic evict_start;
    logic div_step;
    logic rd_victim;
    logic rd_last;
    logic move;
    logic insert;
    logic load_out;
  } rrbc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic match;
    logic idx_last;
    logic hit;
    logic over_cap;
    logic need_evict;
    logic div_last;
    logic out_free;
  } rrbc_stat_t;

endpackage

// ===== design/random_replacement_byte_cache.sv =====
// Byte-budgeted object cache with random replacement. Each request word
// carries a key and a size; one result word comes back per request. The
// entry store is searched one slot at a time (read, compare), and each
// eviction runs the bit-serial modulo that picks the victim, then the victim
// read, the last-entry read and the move. Requests are handled one at a time;
// a new request is taken while the previous result still waits in the output
// register.
// Depends on rrbc_pkg, rrbc_ctrl and rrbc_dp.
module random_replacement_byte_cache
  import rrbc_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_BITS    = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // object_key[31:0], object_bytes[63:32]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // evicted_count[6:0], hit_total[54:7],
                                            // request_total[102:55], zero pad
  output logic [OUT_USER_W-1:0]  m_tuser    // was_hit[0], was_inserted[1], was_rejected[2]
);

  rrbc_cmd_t  cmd;
  rrbc_stat_t stat;

  assign cfg_ready = 1'b1;

  rrbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrbc_dp #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== design/rrbc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rrbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rrbc_ctrl.sv =====
// Controller state machine of the byte cache: search, decide, evict, insert, report.
// Depends on rrbc_pkg for the command and status structs.
module rrbc_ctrl
  import rrbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  rrbc_stat_t stat,
  output rrbc_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SRD    = 10'b0000000010,
    S_SCMP   = 10'b0000000100,
    S_DECIDE = 10'b0000001000,
    S_DIV    = 10'b0000010000,
    S_VRD    = 10'b0000100000,
    S_LRD    = 10'b0001000000,
    S_MOVE   = 10'b0010000000,
    S_INS    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = stat.count_zero ? S_DECIDE : S_SRD;
        end
      end
      S_SRD: begin
        cmd.srch_rd = 1'b1;
        state_next  = S_SCMP;
      end
      S_SCMP: begin
        cmd.srch_cmp = 1'b1;
        if (stat.match || stat.idx_last) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_SRD;
        end
      end
      S_DECIDE: begin
        if (stat.hit) begin
          cmd.do_hit = 1'b1;
          state_next = S_DONE;
        end else if (stat.over_cap) begin
          cmd.do_reject = 1'b1;
          state_next    = S_DONE;
        end else if (stat.need_evict) begin
          cmd.evict_start = 1'b1;
          state_next      = S_DIV;
        end else begin
          state_next = S_INS;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_VRD;
        end
      end
      S_VRD: begin
        cmd.rd_victim = 1'b1;
        state_next    = S_LRD;
      end
      S_LRD: begin
        cmd.rd_last = 1'b1;
        state_next  = S_MOVE;
      end
      S_MOVE: begin
        cmd.move   = 1'b1;
        state_next = S_DECIDE;
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/rrbc_dp.sv =====
// Datapath of the byte cache: entry memory, occupancy, LFSR, remainder unit,
// counters and the result register. Depends on rrbc_pkg and rrbc_ram.
module rrbc_dp
  import rrbc_pkg::*;
#(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_BITS    = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_DATA_W-1:0]   s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,
  output logic [OUT_USER_W-1:0]  m_tuser,
  input  rrbc_cmd_t              cmd,
  output rrbc_stat_t             stat
);

  localparam int KEY_W  = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W  = KEY_W + SIZE_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);

  logic [CAP_W-1:0]      capacity;
  logic [LFSR_W-1:0]     lfsr;
  logic [CNT_W-1:0]      count;
  logic [USED_W-1:0]     bytes_used;
  logic [CNT_OUT_W-1:0]  hits;
  logic [CNT_OUT_W-1:0]  reqs;
  logic [KEY_W-1:0]      key_r;
  logic [SIZE_W-1:0]     size_r;
  logic [ADDR_W-1:0]     idx;
  logic [CNT_W-1:0]      rem;
  logic [LFSR_W-1:0]     dvd;
  logic [DIV_STEP_W-1:0] dstep;
  logic [CNT_W-1:0]      evicted;
  logic [SIZE_W-1:0]     vsize;
  logic                  hit_f, ins_f, rej_f;

  logic [LFSR_W-1:0]     lfsr_step;
  logic [CNT_W:0]        div_t;
  logic [CNT_W-1:0]      last;
  logic [USED_W:0]       need_bytes;

  logic                  we;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [ENT_W-1:0]      wdata, rdata;

  rrbc_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign lfsr_step  = {1'b0, lfsr[LFSR_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
  assign div_t      = {rem, dvd[LFSR_W-1]};
  assign last       = count - CNT_W'(1);
  assign need_bytes = {1'b0, bytes_used} + (USED_W+1)'(size_r);

  always_comb begin
    raddr = idx;
    if (cmd.rd_victim) begin
      raddr = rem[ADDR_W-1:0];
    end else if (cmd.rd_last) begin
      raddr = last[ADDR_W-1:0];
    end
    we    = cmd.move | cmd.insert;
    waddr = cmd.insert ? count[ADDR_W-1:0] : rem[ADDR_W-1:0];
    wdata = cmd.insert ? {key_r, size_r} : rdata;
  end

  always_comb begin
    stat.count_zero = (count == '0);
    stat.match      = (rdata[ENT_W-1:SIZE_W] == key_r);
    stat.idx_last   = ((CNT_W'(idx) + CNT_W'(1)) == count);
    stat.hit        = hit_f;
    stat.over_cap   = ((CAP_W'(size_r)) > capacity);
    stat.need_evict = (count != '0) &&
                      ((need_bytes > (USED_W+1)'(capacity)) || (count >= CNT_FULL));
    stat.div_last   = (dstep == {DIV_STEP_W{1'b1}});
    stat.out_free   = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= '0;
      lfsr       <= LFSR_W'(1);
      count      <= '0;
      bytes_used <= '0;
      hits       <= '0;
      reqs       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_BYTE_CAPACITY: capacity <= cfg_data[CAP_W-1:0];
          REG_RANDOM_SEED: begin
            // A zero seed would lock the LFSR, so it loads as one.
            lfsr <= (cfg_data[LFSR_W-1:0] == '0) ? LFSR_W'(1) : cfg_data[LFSR_W-1:0];
          end
          default: ;
        endcase
      end
      if (cmd.accept && reqs != CNT_MAX) begin
        reqs <= reqs + CNT_OUT_W'(1);
      end
      if (cmd.do_hit && hits != CNT_MAX) begin
        hits <= hits + CNT_OUT_W'(1);
      end
      if (cmd.evict_start) begin
        lfsr <= lfsr_step;
      end
      if (cmd.move) begin
        bytes_used <= bytes_used - USED_W'(vsize);
        count      <= last;
      end else if (cmd.insert) begin
        bytes_used <= bytes_used + USED_W'(size_r);
        count      <= count + CNT_W'(1);
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload and per-word working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r   <= s_tdata[KEY_W-1:0];
      size_r  <= s_tdata[IN_KEY_W +: SIZE_W];
      idx     <= '0;
      hit_f   <= 1'b0;
      ins_f   <= 1'b0;
      rej_f   <= 1'b0;
      evicted <= '0;
    end
    if (cmd.srch_cmp) begin
      if (stat.match) begin
        hit_f <= 1'b1;
      end else begin
        idx <= idx + ADDR_W'(1);
      end
    end
    if (cmd.do_reject) begin
      rej_f <= 1'b1;
    end
    // Victim slot is the new LFSR value modulo the entry count, one bit a cycle.
    if (cmd.evict_start) begin
      dvd   <= lfsr_step;
      rem   <= '0;
      dstep <= '0;
    end
    if (cmd.div_step) begin
      dvd   <= {dvd[LFSR_W-2:0], 1'b0};
      dstep <= dstep + DIV_STEP_W'(1);
      if (div_t >= {1'b0, count}) begin
        rem <= CNT_W'(div_t - {1'b0, count});
      end else begin
        rem <= div_t[CNT_W-1:0];
      end
    end
    if (cmd.rd_last) begin
      vsize <= rdata[SIZE_W-1:0];
    end
    if (cmd.move) begin
      evicted <= evicted + CNT_W'(1);
    end
    if (cmd.insert) begin
      ins_f <= 1'b1;
    end
    if (cmd.load_out) begin
      m_tdata <= {1'b0, reqs, hits, EVICT_OUT_W'(evicted)};
      m_tuser <= {rej_f, ins_f, hit_f};
    end
  end

endmodule

// ===== verif/rrbc_checker.sv =====
// Result checker for the random-replacement byte cache: tracks its own copy
// of the entry store, LFSR and counters from the observed words and compares
// every result word. Depends on rrbc_pkg.
module rrbc_checker
  import rrbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_DATA_W-1:0]  m_tdata,
  input  logic [OUT_USER_W-1:0]  m_tuser,
  output int                     errors,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;

  typedef struct packed {
    logic                   hit;
    logic                   inserted;
    logic                   rejected;
    logic [EVICT_OUT_W-1:0] evicted;
    logic [CNT_OUT_W-1:0]   hit_total;
    logic [CNT_OUT_W-1:0]   req_total;
  } lookup_result_t;

  logic [IN_KEY_W-1:0]  slot_key [SLOTS];
  logic [SIZE_W-1:0]    slot_size[SLOTS];
  int                   slot_count;
  logic [USED_W-1:0]    used_bytes;
  logic [LFSR_W-1:0]    lfsr;
  logic [CNT_OUT_W-1:0] hits, requests;
  logic [CAP_W-1:0]     capacity;
  lookup_result_t       pending_results[$];

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task predict_lookup(input logic [IN_KEY_W-1:0] key, input logic [SIZE_W-1:0] size);
    lookup_result_t r;
    logic [USED_W:0] need;
    int victim, last;
    r = '0;
    if (requests != CNT_MAX) requests++;
    for (int i = 0; i < slot_count; i++)
      if (slot_key[i] == key) r.hit = 1'b1;
    if (r.hit) begin
      if (hits != CNT_MAX) hits++;
    end else if ({8'd0, size} > capacity) begin
      r.rejected = 1'b1;
    end else begin
      need = (USED_W+1)'(used_bytes) + (USED_W+1)'(size);
      while (slot_count > 0 && (need > (USED_W+1)'(capacity) || slot_count >= SLOTS)) begin
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
        victim = int'(lfsr) % slot_count;
        last = slot_count - 1;
        used_bytes = used_bytes - USED_W'(slot_size[victim]);
        slot_key[victim] = slot_key[last];
        slot_size[victim] = slot_size[last];
        slot_count = last;
        r.evicted++;
        need = (USED_W+1)'(used_bytes) + (USED_W+1)'(size);
      end
      slot_key[slot_count] = key;
      slot_size[slot_count] = size;
      slot_count++;
      used_bytes = used_bytes + USED_W'(size);
      r.inserted = 1'b1;
    end
    r.hit_total = hits;
    r.req_total = requests;
    pending_results = {pending_results, r};
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      slot_count = 0;
      used_bytes = '0;
      lfsr = 16'd1;
      hits = '0;
      requests = '0;
      capacity = '0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BYTE_CAPACITY) capacity = cfg_data;
        else if (cfg_index == REG_RANDOM_SEED)
          lfsr = (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("pending request count", 64'd0, 64'd1);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser[0] != want.hit)
            report_mismatch("was_hit", 64'(m_tuser[0]), 64'(want.hit));
          if (m_tuser[1] != want.inserted)
            report_mismatch("was_inserted", 64'(m_tuser[1]), 64'(want.inserted));
          if (m_tuser[2] != want.rejected)
            report_mismatch("was_rejected", 64'(m_tuser[2]), 64'(want.rejected));
          if (m_tdata[6:0] != want.evicted)
            report_mismatch("evicted_count", 64'(m_tdata[6:0]), 64'(want.evicted));
          if (m_tdata[54:7] != want.hit_total)
            report_mismatch("hit_total", 64'(m_tdata[54:7]), 64'(want.hit_total));
          if (m_tdata[102:55] != want.req_total)
            report_mismatch("request_total", 64'(m_tdata[102:55]), 64'(want.req_total));
        end
      end
      // The request is predicted after the result check, so a result leaving
      // in the same cycle is compared against the older expectation.
      if (s_tvalid && s_tready) predict_lookup(s_tdata[31:0], s_tdata[63:32]);
    end
    outstanding = pending_results.size();
  end

  initial begin
    errors = 0;
    outstanding = 0;
  end

endmodule

// ===== verif/tb_random_replacement_byte_cache.sv =====
// Stimulus and verdict for the random-replacement byte cache. Drives the
// request and register channels; rrbc_checker does the prediction.
// Depends on rrbc_pkg, rrbc_checker and the cache RTL.
module tb_random_replacement_byte_cache
  import rrbc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int ITEMS = 1650;

  // Register indexes with no register behind them.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  logic                   clk, rst;
  logic                   cfg_valid, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid, s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   m_tvalid, m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [OUT_USER_W-1:0]  m_tuser;
  int                     errors, outstanding;
  int                     send_idle_pct, recv_idle_pct;
  int                     hold_req, hold_seen, hold_left, quiet_cycles;
  int                     sent;

  random_replacement_byte_cache u_dut (.*);
  rrbc_checker u_checker (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_req;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[random_replacement_byte_cache] ERROR");
      $finish;
    end
  end

  task write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task send_request(input logic [31:0] key, input logic [31:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {size, key};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    sent++;
  endtask

  // The checker books the last word at the edge just passed, so the count is
  // looked at only from the following falling edge on.
  task drain;
    s_tvalid <= 1'b0;
    @(negedge clk);
    wait (outstanding == 0);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    logic [CAP_W-1:0] caps[5];
    logic [15:0]      seeds[5];
    logic [31:0]      key, size;
    int               pick;
    caps = '{40'd5000, {CAP_W{1'b1}}, 40'd0, 40'd300000, 40'd1000};
    seeds = '{16'd0, 16'hFFFF, 16'(($urandom_range(65534)) + 1), 16'd1, 16'h8001};
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0;
    send_idle_pct = 25; recv_idle_pct = 70;
    hold_req = 0; sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at a capacity of 1000 bytes.
    write_reg(REG_BYTE_CAPACITY, 40'd1000);
    write_reg(REG_RANDOM_SEED, 40'd0);
    write_reg(REG_UNMAPPED_LO, 40'hFF_FFFF_FFFF);
    write_reg(REG_UNMAPPED_HI, 40'h12345);
    send_request(32'h0, 32'h0);                 // zero-size object still takes a slot
    send_request(32'h0, 32'h5);                 // hit
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF); // larger than the capacity
    send_request(32'hFFFF_FFFF, 32'd1000);      // exactly the capacity
    send_request(32'h1, 32'd1);                 // forces an eviction
    send_request(32'h1234_5678, 32'd1001);
    send_request(32'hFFFF_FFFF, 32'd7);
    send_request(32'h8000_0000, 32'd400);
    send_request(32'h5555_5555, 32'd300);
    send_request(32'hAAAA_AAAA, 32'd300);
    send_request(32'h8000_0000, 32'd1);
    send_request(32'h2, 32'd999);
    send_request(32'h1, 32'd0);
    drain();
    // Capacity lowered below what is in use.
    write_reg(REG_BYTE_CAPACITY, 40'd10);
    send_request(32'h2, 32'd0);
    send_request(32'h3, 32'd10);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_BYTE_CAPACITY, caps[ph]);
      write_reg(REG_RANDOM_SEED, {24'd0, seeds[ph]});
      for (int n = 0; n < ITEMS / 5; n++) begin
        if (sent < 550) begin
          send_idle_pct = 25; recv_idle_pct = 70;
        end else if (sent < 1100) begin
          send_idle_pct = 70; recv_idle_pct = 25;
        end else begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        if (ph == 3 && n == 100) hold_req++;
        if (ph == 3 && n == 200) drain();
        key = ($urandom_range(99) < 75) ? 32'($urandom_range(149)) : $urandom;
        pick = $urandom_range(99);
        if (pick < 15) size = 32'd0;
        else if (pick < 25) size = $urandom;
        else if (pick < 70) size = 32'($urandom_range(255));
        else size = (caps[ph] > 40'hFFFF_FFFF) ? $urandom
                    : 32'($urandom_range(32'(caps[ph]) + 32'd1));
        send_request(key, size);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) $display("[random_replacement_byte_cache] OK");
    else $display("[random_replacement_byte_cache] ERROR");
    $finish;
  end

endmodule
